@@ hw/rtl/at_rsp_pkg.sv @@
// ----------------------------------------------------------------------------
// AT response parser package
// Shared state codes, event codes and reply-name characters.
// ----------------------------------------------------------------------------
package at_rsp_pkg;

  typedef enum logic [3:0] {
    ST_START = 4'd0,
    ST_ERR   = 4'd1,
    ST_RESP  = 4'd2,
    ST_DATA  = 4'd3,
    ST_OK    = 4'd4,
    ST_ROK   = 4'd5,
    ST_SKIP  = 4'd6,
    ST_MTU   = 4'd7,
    ST_CNF   = 4'd8
  } parse_state_e;

  typedef enum logic [3:0] {
    EV_NONE   = 4'd0,
    EV_READY  = 4'd1,
    EV_OK     = 4'd2,
    EV_ERROR  = 4'd3,
    EV_PAIRED = 4'd4,
    EV_INCOM  = 4'd5,
    EV_CONN   = 4'd6,
    EV_DISC   = 4'd7,
    EV_DATA   = 4'd8
  } event_e;

  localparam int unsigned ValueW = 10;

  localparam logic [31:0] NAME_RSLE = "RSLE";
  localparam logic [31:0] NAME_RCOI = "RCOI";
  localparam logic [31:0] NAME_RCCR = "RCCR";
  localparam logic [31:0] NAME_RDII = "RDII";
  localparam logic [31:0] NAME_RDAI = "RDAI";
  localparam logic [31:0] NAME_ERR  = "RR=-";
  localparam logic [15:0] NAME_OK   = "OK";

  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_E     = "E";
  localparam logic [7:0] CH_O     = "O";
  localparam logic [7:0] CH_R     = "R";
  localparam logic [7:0] CH_K     = "K";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = "0";

endpackage

@@ hw/rtl/at_response_parser_core.sv @@
// ----------------------------------------------------------------------------
// AT response parser core
// Recognizes the radio module's AT replies in its serial receive stream and
// reports one event per received byte.
// ----------------------------------------------------------------------------
// The parser takes one received byte per cycle unless the output stalls, and
// returns one result item for every byte from its output register in the next
// cycle. Parse state, the name buffer, the digit counters and the link flag all
// update in the single cycle in which a byte is accepted, so bytes may arrive
// back to back and a new byte is taken whenever the output register is empty or
// being drained in the same cycle.
module at_response_parser_core
  import at_rsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        event_res_o,
  output logic [ValueW-1:0] event_value_o,
  output logic              data_last_o,
  output logic              link_connected_o,
  output logic              parser_idle_o
);

  parse_state_e      state_q, state_d;
  logic [7:0]        buf_q [4];
  logic [2:0]        idx_q, idx_d;
  logic [2:0]        dcnt_q, dcnt_d;
  logic [ValueW-1:0] mtu_q, mtu_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic              link_q, link_d;

  logic              buf_we;
  logic [1:0]        buf_wa;

  logic              out_valid_q;
  event_e            ev_q, ev_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              last_q, last_d;
  logic              idle_q;

  logic              accept;
  logic [7:0]        n;
  logic              bad_digit;
  logic [ValueW-1:0] n_ext;
  logic [ValueW-1:0] n_x10;
  logic [ValueW-1:0] n_x100;
  logic [ValueW-1:0] rem_dec;
  logic [31:0]       name4;
  logic [15:0]       name2;

  assign accept    = in_valid_i & ~in_stall_o;
  assign n         = rx_byte_i - CH_ZERO;
  assign bad_digit = n > 8'd9;
  assign n_ext     = {{(ValueW-4){1'b0}}, n[3:0]};
  assign n_x10     = n_ext * ValueW'(10);
  assign n_x100    = n_ext * ValueW'(100);
  assign rem_dec   = rem_q - ValueW'(1);
  assign name4     = {buf_q[0], buf_q[1], buf_q[2], buf_q[3]};
  assign name2     = {buf_q[0], buf_q[1]};
  assign buf_wa    = idx_q[1:0];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    dcnt_d  = dcnt_q;
    mtu_d   = mtu_q;
    rem_d   = rem_q;
    link_d  = link_q;
    buf_we  = 1'b0;
    ev_d    = EV_NONE;
    val_d   = '0;
    last_d  = 1'b0;
    unique case (state_q)
      ST_START: begin
        idx_d = '0;
        if (rx_byte_i == CH_PLUS) begin
          state_d = ST_RESP;
        end else if (rx_byte_i == CH_E) begin
          state_d = ST_ERR;
        end else if (rx_byte_i == CH_O) begin
          state_d = ST_OK;
        end else if (rx_byte_i == CH_R) begin
          state_d = ST_ROK;
        end
      end
      ST_ROK: begin
        if (idx_q < 3'd2) begin
          buf_we = 1'b1;
          idx_d  = idx_q + 3'd1;
        end else begin
          if (name2 == NAME_OK) ev_d = EV_READY;
          state_d = ST_SKIP;
        end
      end
      ST_OK: begin
        if (rx_byte_i == CH_K) ev_d = EV_OK;
        state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (rx_byte_i == CH_LF) state_d = ST_START;
      end
      ST_ERR: begin
        if (idx_q < 3'd4) begin
          buf_we = 1'b1;
          idx_d  = idx_q + 3'd1;
        end else begin
          if (name4 == NAME_ERR) begin
            ev_d  = EV_ERROR;
            val_d = {{(ValueW-8){1'b0}}, n};
          end
          state_d = ST_SKIP;
        end
      end
      ST_RESP: begin
        if (idx_q < 3'd4) begin
          buf_we = 1'b1;
          idx_d  = idx_q + 3'd1;
        end else begin
          state_d = ST_SKIP;
          if (name4 == NAME_RSLE) begin
            ev_d = EV_PAIRED;
          end else if (name4 == NAME_RCOI) begin
            ev_d = EV_INCOM;
          end else if (name4 == NAME_RCCR) begin
            state_d = ST_CNF;
          end else if (name4 == NAME_RDII) begin
            ev_d   = EV_DISC;
            link_d = 1'b0;
          end else if (name4 == NAME_RDAI) begin
            state_d = ST_DATA;
            dcnt_d  = '0;
            rem_d   = '0;
          end
        end
      end
      ST_CNF: begin
        if (rx_byte_i == CH_EQ) begin
          state_d = ST_MTU;
          dcnt_d  = '0;
          mtu_d   = '0;
        end
      end
      ST_MTU: begin
        if (bad_digit) begin
          state_d = ST_START;
        end else if (dcnt_q == 3'd0) begin
          mtu_d  = n_x100;
          dcnt_d = 3'd1;
        end else if (dcnt_q == 3'd1) begin
          mtu_d  = mtu_q + n_x10;
          dcnt_d = 3'd2;
        end else begin
          mtu_d   = mtu_q + n_ext;
          dcnt_d  = 3'd3;
          link_d  = 1'b1;
          ev_d    = EV_CONN;
          val_d   = mtu_q + n_ext;
          state_d = ST_SKIP;
        end
      end
      ST_DATA: begin
        if (dcnt_q < 3'd3) begin
          if (bad_digit) begin
            state_d = ST_START;
          end else begin
            if (dcnt_q == 3'd0) begin
              rem_d = rem_q + n_x100;
            end else if (dcnt_q == 3'd1) begin
              rem_d = rem_q + n_x10;
            end else begin
              rem_d = rem_q + n_ext;
            end
            dcnt_d = dcnt_q + 3'd1;
          end
        end else if (dcnt_q == 3'd3) begin
          if (rx_byte_i != CH_COMMA) begin
            state_d = ST_START;
          end else begin
            dcnt_d = 3'd4;
            if (rem_q == '0) state_d = ST_SKIP;
          end
        end else begin
          rem_d = rem_dec;
          ev_d  = EV_DATA;
          val_d = {{(ValueW-8){1'b0}}, rx_byte_i};
          if (rem_dec == '0) begin
            last_d  = 1'b1;
            state_d = ST_SKIP;
          end
        end
      end
      default: begin
        state_d = ST_START;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      idx_q   <= '0;
      dcnt_q  <= '0;
      mtu_q   <= '0;
      rem_q   <= '0;
      link_q  <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
      idx_q   <= idx_d;
      dcnt_q  <= dcnt_d;
      mtu_q   <= mtu_d;
      rem_q   <= rem_d;
      link_q  <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && buf_we) begin
      buf_q[buf_wa] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q   <= ev_d;
      val_q  <= val_d;
      last_q <= last_d;
      idle_q <= (state_d == ST_START);
    end
  end

  assign in_stall_o       = out_valid_q & out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign event_res_o      = ev_q;
  assign event_value_o    = val_q;
  assign data_last_o      = last_q;
  assign link_connected_o = link_q;
  assign parser_idle_o    = idle_q;

endmodule

@@ hw/rtl/at_rsp_checker.sv @@
// ----------------------------------------------------------------------------
// AT response parser checker
// Port-level assertions on the parser's result items, bound to the core.
// ----------------------------------------------------------------------------
module at_rsp_checker
  import at_rsp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [7:0]        rx_byte_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [3:0]        event_res_o,
  input logic [ValueW-1:0] event_value_o,
  input logic              data_last_o,
  input logic              link_connected_o,
  input logic              parser_idle_o
);

  // A stalled item stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
    $stable(event_value_o) && $stable(data_last_o) && $stable(parser_idle_o))
    else $error("stalled result item changed");

  // The last payload byte is a data event and leaves the parser skipping the line.
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_last_o |-> event_res_o == EV_DATA && !parser_idle_o)
    else $error("data_last outside a final data event");

  // Only error, connected and data events carry a value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_ERROR && event_res_o != EV_CONN &&
    event_res_o != EV_DATA |-> event_value_o == '0)
    else $error("value on an event that carries none");

  // Connect and disconnect events agree with the link flag.
  a_link_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_CONN || event_res_o == EV_DISC) |->
    link_connected_o == (event_res_o == EV_CONN))
    else $error("link flag disagrees with link event");

endmodule

bind at_response_parser_core at_rsp_checker u_at_rsp_checker (.*);
